/* hdl/hsv_to_rgb_converter_unit_macros.svh */
// Assertion macros for the HSV to RGB converter.
// Used by hsv_to_rgb_converter_unit.sv; expects clk_i and rst_ni in scope.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HSV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter_unit: assertion failed");

// Next-cycle implication, disabled while in reset.
`define HSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter_unit: assertion failed");

`endif

/* hdl/hsv2rgb_pkg.sv */
// Types and constants for the HSV to RGB converter.
// No dependencies; imported by hsv_to_rgb_converter_unit.
`default_nettype none

package hsv2rgb_pkg;

  // Hue wraps at 360 degrees, in sixteenths of a degree.
  localparam logic [12:0] HueFull   = 13'd5760;
  localparam logic [9:0]  HueSector = 10'd960;
  localparam logic [7:0]  FracOne   = 8'd255;
  // 255 * 960
  localparam logic [17:0] DenFull   = 18'd244800;

  // Exact reciprocals: floor(x / d) == (x * R) >> Shift over the whole input range.
  localparam int unsigned MShift = 24;  // x < 2^16, d = 255
  localparam logic [16:0] MRecip = 17'(((64'd1 << 24) + 64'd254) / 64'd255);
  localparam int unsigned NShift = 44;  // x < 2^26, d = 244800
  localparam logic [26:0] NRecip = 27'(((64'd1 << 44) + 64'd244799) / 64'd244800);

  typedef enum logic [2:0] {
    SecRy = 3'd0,  // red to yellow
    SecYg = 3'd1,  // yellow to green
    SecGc = 3'd2,  // green to cyan
    SecCb = 3'd3,  // cyan to blue
    SecBm = 3'd4,  // blue to magenta
    SecMr = 3'd5   // magenta to red
  } sector_e;

  function automatic logic [12:0] sector_base(input sector_e sec);
    logic [12:0] base;
    unique case (sec)
      SecRy:   base = 13'd0;
      SecYg:   base = 13'd960;
      SecGc:   base = 13'd1920;
      SecCb:   base = 13'd2880;
      SecBm:   base = 13'd3840;
      SecMr:   base = 13'd4800;
      default: base = 13'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

/* hdl/hsv_to_rgb_converter_unit.sv */
// HSV with alpha to RGB with alpha, six-stage pipeline.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_unit_macros.svh.
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ----------------------
//  pixel in  hue_i saturation_i brightness_i alpha_in_i   start_i, busy_o
//  pixel out red_o green_o blue_o alpha_out_o             valid_o
//
// One pixel per clock; valid_o is the last bit of the valid shift register and rises
// together with the stage-6 result registers.
// Stages: hue wrap, sector split, fraction products, channel products,
// reciprocal scaling, channel ordering. Each stage holds at most one multiplier per path.
// busy_o stays low: every stage advances each cycle and nothing waits downstream.
// Reset clears the valid bits only; data registers carry no reset.
`default_nettype none

`include "hsv_to_rgb_converter_unit_macros.svh"

module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [12:0] hue_i,
  input  wire logic [7:0]  saturation_i,
  input  wire logic [7:0]  brightness_i,
  input  wire logic [7:0]  alpha_in_i,
  output logic             valid_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_out_o
);

  logic [5:0] vld_q, vld_d;

  // stage 1: wrapped hue
  logic [12:0] hue1_q, hue1_d;
  logic [7:0]  sat1_q, bri1_q, alp1_q;
  // stage 2: sector and remainder
  sector_e     sec2_q, sec2_d;
  logic [9:0]  rem2_q, rem2_d;
  logic [7:0]  sat2_q, bri2_q, alp2_q;
  // stage 3: fraction products
  logic [17:0] pn3_q, pn3_d, pk3_q, pk3_d;
  logic [15:0] mnum3_q, mnum3_d;
  logic [7:0]  bri3_q, alp3_q;
  sector_e     sec3_q;
  logic        gry3_q;
  // stage 4: channel products, M scaled
  logic [25:0] xn4_q, xn4_d, xk4_q, xk4_d;
  logic [32:0] mprod;
  logic [7:0]  m4_q, bri4_q, alp4_q;
  sector_e     sec4_q;
  logic        gry4_q;
  // stage 5: N and K scaled
  logic [52:0] nprod, kprod;
  logic [7:0]  n5_q, k5_q, m5_q, bri5_q, alp5_q;
  sector_e     sec5_q;
  logic        gry5_q;
  // stage 6: output
  logic [7:0]  red_q, grn_q, blu_q, alp6_q;
  logic [7:0]  red_d, grn_d, blu_d;
  logic        gry6_q;

  assign busy_o = 1'b0;

  always_comb begin
    vld_d = {vld_q[4:0], start_i & ~busy_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: wrap hue once
  always_comb begin
    hue1_d = (hue_i >= HueFull) ? 13'(hue_i - HueFull) : hue_i;
  end

  // stage 2: split hue into sector and remainder
  always_comb begin
    priority if (hue1_q >= sector_base(SecMr)) begin
      sec2_d = SecMr;
    end else if (hue1_q >= sector_base(SecBm)) begin
      sec2_d = SecBm;
    end else if (hue1_q >= sector_base(SecCb)) begin
      sec2_d = SecCb;
    end else if (hue1_q >= sector_base(SecGc)) begin
      sec2_d = SecGc;
    end else if (hue1_q >= sector_base(SecYg)) begin
      sec2_d = SecYg;
    end else begin
      sec2_d = SecRy;
    end
    rem2_d = 10'(hue1_q - sector_base(sec2_d));
  end

  // stage 3: S*rem, S*(960-rem), V*(255-S)
  always_comb begin
    pn3_d   = 18'(sat2_q) * 18'(rem2_q);
    pk3_d   = 18'(sat2_q) * 18'(10'(HueSector - rem2_q));
    mnum3_d = 16'(bri2_q) * 16'(8'(FracOne - sat2_q));
  end

  // stage 4: V*(244800-p) and M = mnum/255
  always_comb begin
    xn4_d = 26'(bri3_q) * 26'(18'(DenFull - pn3_q));
    xk4_d = 26'(bri3_q) * 26'(18'(DenFull - pk3_q));
    mprod = 33'(mnum3_q) * 33'(MRecip);
  end

  // stage 5: N and K = x/244800
  always_comb begin
    nprod = 53'(xn4_q) * 53'(NRecip);
    kprod = 53'(xk4_q) * 53'(NRecip);
  end

  // stage 6: order channels by sector
  always_comb begin
    unique case (sec5_q)
      SecRy: begin red_d = bri5_q; grn_d = k5_q;   blu_d = m5_q;   end
      SecYg: begin red_d = n5_q;   grn_d = bri5_q; blu_d = m5_q;   end
      SecGc: begin red_d = m5_q;   grn_d = bri5_q; blu_d = k5_q;   end
      SecCb: begin red_d = m5_q;   grn_d = n5_q;   blu_d = bri5_q; end
      SecBm: begin red_d = k5_q;   grn_d = m5_q;   blu_d = bri5_q; end
      default: begin red_d = bri5_q; grn_d = m5_q; blu_d = n5_q;   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    hue1_q  <= hue1_d;
    sat1_q  <= saturation_i;
    bri1_q  <= brightness_i;
    alp1_q  <= alpha_in_i;

    sec2_q  <= sec2_d;
    rem2_q  <= rem2_d;
    sat2_q  <= sat1_q;
    bri2_q  <= bri1_q;
    alp2_q  <= alp1_q;

    pn3_q   <= pn3_d;
    pk3_q   <= pk3_d;
    mnum3_q <= mnum3_d;
    bri3_q  <= bri2_q;
    alp3_q  <= alp2_q;
    sec3_q  <= sec2_q;
    gry3_q  <= (sat2_q == 8'd0);

    xn4_q   <= xn4_d;
    xk4_q   <= xk4_d;
    m4_q    <= mprod[MShift+7:MShift];
    bri4_q  <= bri3_q;
    alp4_q  <= alp3_q;
    sec4_q  <= sec3_q;
    gry4_q  <= gry3_q;

    n5_q    <= nprod[NShift+7:NShift];
    k5_q    <= kprod[NShift+7:NShift];
    m5_q    <= m4_q;
    bri5_q  <= bri4_q;
    alp5_q  <= alp4_q;
    sec5_q  <= sec4_q;
    gry5_q  <= gry4_q;

    red_q   <= red_d;
    grn_q   <= grn_d;
    blu_q   <= blu_d;
    alp6_q  <= alp5_q;
    gry6_q  <= gry5_q;
  end

  assign valid_o     = vld_q[5];
  assign red_o       = red_q;
  assign green_o     = grn_q;
  assign blue_o      = blu_q;
  assign alpha_out_o = alp6_q;

  // remainder stays inside one sector
  `HSV_ASSERT_NOW(a_rem_range, vld_q[1], rem2_q < HueSector)
  // scaled channels never exceed the value
  `HSV_ASSERT_NOW(a_chan_bound, vld_q[4], (n5_q <= bri5_q) && (k5_q <= bri5_q) && (m5_q <= bri5_q))
  // zero saturation gives grey
  `HSV_ASSERT_NOW(a_grey, valid_o && gry6_q, (red_o == green_o) && (green_o == blue_o))

endmodule

`default_nettype wire
